FILE: rtl/btt_pkg.sv
// ----------------------------------------------------------------------------
// btt_pkg
// Shared types, codes and field widths of the button edge timestamp tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package btt_pkg;

  // Defaults for the top level parameters
  localparam int unsigned NUM_BUTTONS_DEF = 32;
  localparam int unsigned TIME_BITS_DEF   = 48;

  // Fixed port field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned MASK_W  = 32;
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned KIND_W  = 4;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned FLAG_W  = 10;
  localparam int unsigned CNT_W   = 8;

  localparam int unsigned NUM_FLAG_MASKS = 5;
  localparam int unsigned NUM_COUNTERS   = 4;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_START  = 2'd0,
    CMD_EVENT  = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // Event kinds; codes above EV_IGNORE are dropped as well
  typedef enum logic [KIND_W-1:0] {
    EV_PRESS    = 4'd0,
    EV_RELEASE  = 4'd1,
    EV_TAP      = 4'd2,
    EV_HOLD     = 4'd3,
    EV_COMBO    = 4'd4,
    EV_GESTURE  = 4'd5,
    EV_TPRESS   = 4'd6,
    EV_TRELEASE = 4'd7,
    EV_TSLIDE   = 4'd8,
    EV_IGNORE   = 4'd9
  } kind_e;

  // Bit positions in the record flags
  localparam int unsigned FLG_DOWN     = 0;
  localparam int unsigned FLG_PRESSED  = 1;
  localparam int unsigned FLG_RELEASED = 2;
  localparam int unsigned FLG_HELD     = 3;
  localparam int unsigned FLG_SAWPRESS = 4;
  localparam int unsigned FLG_SAWREL   = 5;
  localparam int unsigned FLG_TAP      = 6;
  localparam int unsigned FLG_HOLD     = 7;
  localparam int unsigned FLG_COMBO    = 8;
  localparam int unsigned FLG_PULSE    = 9;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_SWEEP = 2'd2,
    ST_EMIT  = 2'd3
  } state_e;

  // Sequencer to datapath controls
  typedef struct packed {
    logic busy;     // input side stalled
    logic clr;      // reset clearing pass: zero both RAMs at addr
    logic sweep;    // frame start pass: read edge RAM, zero event RAM
    logic emit_rd;  // record read at addr
    logic s1_load;  // RAM read data moves into the output register
    logic s1_last;  // that word is the final record
  } seq_t;

endpackage : btt_pkg

FILE: rtl/button_edge_timestamp_tracker.sv
// ----------------------------------------------------------------------------
// button_edge_timestamp_tracker
// Frame start: input stalls for a sweep over all NUM_BUTTONS RAM entries
//   (edge RAM read-modify-write, event RAM clear); events go back to back.
// Finish: NUM_BUTTONS records via the output register, 1 record per cycle
//   unless the output stalls, paced by the single read port of each RAM.
// Reset: a clearing pass zeroes both RAMs; input is stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Per-button times live in two RAMs of NUM_BUTTONS entries each:
//   edge RAM  : {release edge time, press edge time}
//   event RAM : {latest release event time, earliest press event time}
// Masks, frame time, event flag masks and saturating counters are flops.
//
// Frame start updates the masks, then the sequencer sweeps every button:
// the edge RAM entry is read and written back in the next cycle with the new
// press or release stamp, and the event RAM entry is zeroed.
//
// Press and release events run a two stage read-modify-write on the event
// RAM: read at acceptance, compare and write the next cycle. A back-to-back
// event on the same button takes the pending write data through a forward
// register instead of the stale RAM word.
//
// Finish hands control to the sequencer, which reads both RAMs per button;
// btt_rec builds the record and holds it in the output register, so read-out
// pauses under output stall and the input side reopens as soon as the last
// record sits in the output register.

module button_edge_timestamp_tracker #(
  parameter int unsigned NUM_BUTTONS = btt_pkg::NUM_BUTTONS_DEF,
  parameter int unsigned TIME_BITS   = btt_pkg::TIME_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input words
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [btt_pkg::CMD_W-1:0]   command_i,
  input  logic [btt_pkg::MASK_W-1:0]  down_mask_i,
  input  logic [btt_pkg::TIME_W-1:0]  time_us_i,
  input  logic [btt_pkg::KIND_W-1:0]  event_kind_i,
  input  logic [btt_pkg::MASK_W-1:0]  event_code_i,
  // record words
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [btt_pkg::IDX_W-1:0]   button_index_o,
  output logic [btt_pkg::FLAG_W-1:0]  flags_o,
  output logic [btt_pkg::TIME_W-1:0]  pressed_at_us_o,
  output logic [btt_pkg::TIME_W-1:0]  released_at_us_o,
  output logic [btt_pkg::TIME_W-1:0]  held_us_o,
  output logic [btt_pkg::TIME_W-1:0]  first_press_us_o,
  output logic [btt_pkg::TIME_W-1:0]  last_release_us_o,
  output logic [btt_pkg::CNT_W-1:0]   gesture_count_o,
  output logic [btt_pkg::CNT_W-1:0]   touch_press_count_o,
  output logic [btt_pkg::CNT_W-1:0]   touch_release_count_o,
  output logic [btt_pkg::CNT_W-1:0]   touch_slide_count_o,
  output logic                        last_record_o
);

  localparam int unsigned IW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int unsigned PW = 2 * TIME_BITS;
  // valid button bits within the 32-bit code
  localparam logic [btt_pkg::MASK_W-1:0] BTN_MASK =
    btt_pkg::MASK_W'((64'd1 << NUM_BUTTONS) - 64'd1);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  btt_pkg::seq_t ctl;
  logic [IW-1:0] seq_addr;
  logic [IW-1:0] s1_idx;
  logic          out_free;
  logic          acc;
  logic          is_start, is_event, is_finish;

  assign in_stall_o = ctl.busy;
  assign acc        = in_valid_i && !in_stall_o;
  assign is_start   = acc && (command_i == btt_pkg::CMD_START);
  assign is_event   = acc && (command_i == btt_pkg::CMD_EVENT);
  assign is_finish  = acc && (command_i == btt_pkg::CMD_FINISH);

  btt_ctl #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_ctl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (is_start),
    .finish_i  (is_finish),
    .out_free_i(out_free),
    .ctl_o     (ctl),
    .addr_o    (seq_addr),
    .s1_idx_o  (s1_idx)
  );

  // --------------------------------------------------------------------------
  // Frame state
  // --------------------------------------------------------------------------
  logic [NUM_BUTTONS-1:0] frame_mask_q, prev_mask_q;
  logic [TIME_BITS-1:0]   frame_time_q;
  logic [TIME_BITS-1:0]   t_in;

  assign t_in = TIME_BITS'(time_us_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_mask_q <= '0;
      prev_mask_q  <= '0;
      frame_time_q <= '0;
    end else if (is_start) begin
      prev_mask_q  <= frame_mask_q;
      frame_mask_q <= down_mask_i[NUM_BUTTONS-1:0];
      frame_time_q <= t_in;
    end
  end

  // --------------------------------------------------------------------------
  // Event decode
  // --------------------------------------------------------------------------
  logic [TIME_BITS-1:0] ev_t;
  logic                 code_ok;
  logic [IW-1:0]        ev_b;
  logic                 ev_press, ev_release;
  logic                 ev_rd;
  logic                 flag_hit;
  logic                 ctr_hit;
  logic [1:0]           ctr_sel;

  assign ev_t    = (t_in == '0) ? frame_time_q : t_in;
  assign code_ok = (event_code_i != '0) &&
                   ((event_code_i & (event_code_i - 1'b1)) == '0) &&
                   ((event_code_i & ~BTN_MASK) == '0);

  // one-hot code to button number
  always_comb begin
    ev_b = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (event_code_i[i]) ev_b = ev_b | IW'(i);
    end
  end

  assign ev_press   = (event_kind_i == btt_pkg::EV_PRESS);
  assign ev_release = (event_kind_i == btt_pkg::EV_RELEASE);
  assign ev_rd      = is_event && code_ok && (ev_press || ev_release);
  assign flag_hit   = is_event && code_ok &&
                      (event_kind_i inside {[btt_pkg::EV_PRESS:btt_pkg::EV_COMBO]});
  assign ctr_hit    = is_event &&
                      (event_kind_i inside {[btt_pkg::EV_GESTURE:btt_pkg::EV_TSLIDE]});
  assign ctr_sel    = 2'(event_kind_i - btt_pkg::EV_GESTURE);

  // --------------------------------------------------------------------------
  // Event flag masks and counters, cleared on frame start
  // --------------------------------------------------------------------------
  logic [btt_pkg::NUM_FLAG_MASKS-1:0][NUM_BUTTONS-1:0]    flag_q;
  logic [btt_pkg::NUM_COUNTERS-1:0][btt_pkg::CNT_W-1:0]   ctr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= '0;
      ctr_q  <= '0;
    end else if (is_start) begin
      flag_q <= '0;
      ctr_q  <= '0;
    end else begin
      if (flag_hit) begin
        flag_q[event_kind_i[2:0]] <= flag_q[event_kind_i[2:0]] |
                                     event_code_i[NUM_BUTTONS-1:0];
      end
      if (ctr_hit && (ctr_q[ctr_sel] != '1)) begin
        ctr_q[ctr_sel] <= ctr_q[ctr_sel] + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Event RAM read-modify-write
  // --------------------------------------------------------------------------
  logic                 ev_v_q;
  logic                 ev_rel_q;
  logic [IW-1:0]        ev_addr_q;
  logic [TIME_BITS-1:0] ev_t_q;
  logic                 fwd_q;
  logic [PW-1:0]        fwd_data_q;
  logic [PW-1:0]        evt_rdata;
  logic [PW-1:0]        ev_old;
  logic [TIME_BITS-1:0] old_first, old_last;
  logic [TIME_BITS-1:0] new_first, new_last;
  logic [PW-1:0]        ev_wdata;

  assign ev_old    = fwd_q ? fwd_data_q : evt_rdata;
  assign old_first = ev_old[TIME_BITS-1:0];
  assign old_last  = ev_old[PW-1:TIME_BITS];

  always_comb begin
    new_first = old_first;
    new_last  = old_last;
    if (ev_rel_q) begin
      if (ev_t_q > old_last) new_last = ev_t_q;
    end else begin
      if ((old_first == '0) || (ev_t_q < old_first)) new_first = ev_t_q;
    end
  end

  assign ev_wdata = {new_last, new_first};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_v_q <= 1'b0;
      fwd_q  <= 1'b0;
    end else begin
      ev_v_q <= ev_rd;
      // write in flight to the entry being read: take it next cycle
      fwd_q  <= ev_rd && ev_v_q && (ev_addr_q == ev_b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_rd) begin
      ev_rel_q  <= ev_release;
      ev_addr_q <= ev_b;
      ev_t_q    <= ev_t;
    end
    fwd_data_q <= ev_wdata;
  end

  logic          evt_we;
  logic [IW-1:0] evt_waddr;
  logic [PW-1:0] evt_wdata;
  logic          evt_re;
  logic [IW-1:0] evt_raddr;

  assign evt_we    = ctl.clr || ctl.sweep || ev_v_q;
  assign evt_waddr = (ctl.clr || ctl.sweep) ? seq_addr : ev_addr_q;
  assign evt_wdata = (ctl.clr || ctl.sweep) ? '0 : ev_wdata;
  assign evt_re    = ev_rd || ctl.emit_rd;
  assign evt_raddr = ctl.emit_rd ? seq_addr : ev_b;

  btt_ram #(
    .WIDTH(PW),
    .DEPTH(NUM_BUTTONS)
  ) u_evt_ram (
    .clk_i  (clk_i),
    .we_i   (evt_we),
    .waddr_i(evt_waddr),
    .wdata_i(evt_wdata),
    .re_i   (evt_re),
    .raddr_i(evt_raddr),
    .rdata_o(evt_rdata)
  );

  // --------------------------------------------------------------------------
  // Edge RAM: frame start sweep writes back in the cycle after each read
  // --------------------------------------------------------------------------
  logic                 sw_v_q;
  logic [IW-1:0]        sw_addr_q;
  logic [PW-1:0]        edge_rdata;
  logic                 sw_pr, sw_rl;
  logic                 edge_we;
  logic [IW-1:0]        edge_waddr;
  logic [PW-1:0]        edge_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_v_q <= 1'b0;
    end else begin
      sw_v_q <= ctl.sweep;
    end
  end

  always_ff @(posedge clk_i) begin
    sw_addr_q <= seq_addr;
  end

  assign sw_pr = frame_mask_q[sw_addr_q] && !prev_mask_q[sw_addr_q];
  assign sw_rl = !frame_mask_q[sw_addr_q] && prev_mask_q[sw_addr_q];

  assign edge_we    = ctl.clr || (sw_v_q && (sw_pr || sw_rl));
  assign edge_waddr = ctl.clr ? seq_addr : sw_addr_q;
  assign edge_wdata = ctl.clr ? '0 :
                      {(sw_rl ? frame_time_q : edge_rdata[PW-1:TIME_BITS]),
                       (sw_pr ? frame_time_q : edge_rdata[TIME_BITS-1:0])};

  btt_ram #(
    .WIDTH(PW),
    .DEPTH(NUM_BUTTONS)
  ) u_edge_ram (
    .clk_i  (clk_i),
    .we_i   (edge_we),
    .waddr_i(edge_waddr),
    .wdata_i(edge_wdata),
    .re_i   (ctl.sweep || ctl.emit_rd),
    .raddr_i(seq_addr),
    .rdata_o(edge_rdata)
  );

  // --------------------------------------------------------------------------
  // Record build and output register
  // --------------------------------------------------------------------------
  btt_rec #(
    .NUM_BUTTONS(NUM_BUTTONS),
    .TIME_BITS  (TIME_BITS)
  ) u_rec (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .load_i               (ctl.s1_load),
    .last_i               (ctl.s1_last),
    .idx_i                (s1_idx),
    .edge_data_i          (edge_rdata),
    .evt_data_i           (evt_rdata),
    .frame_mask_i         (frame_mask_q),
    .prev_mask_i          (prev_mask_q),
    .flag_masks_i         (flag_q),
    .counts_i             (ctr_q),
    .frame_time_i         (frame_time_q),
    .out_stall_i          (out_stall_i),
    .out_valid_o          (out_valid_o),
    .out_free_o           (out_free),
    .button_index_o       (button_index_o),
    .flags_o              (flags_o),
    .pressed_at_us_o      (pressed_at_us_o),
    .released_at_us_o     (released_at_us_o),
    .held_us_o            (held_us_o),
    .first_press_us_o     (first_press_us_o),
    .last_release_us_o    (last_release_us_o),
    .gesture_count_o      (gesture_count_o),
    .touch_press_count_o  (touch_press_count_o),
    .touch_release_count_o(touch_release_count_o),
    .touch_slide_count_o  (touch_slide_count_o),
    .last_record_o        (last_record_o)
  );

endmodule : button_edge_timestamp_tracker

FILE: rtl/btt_ram.sv
// ----------------------------------------------------------------------------
// btt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btt_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : btt_ram

FILE: rtl/btt_ctl.sv
// ----------------------------------------------------------------------------
// btt_ctl
// Sequencer: reset clearing pass, frame start sweep and record read-out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btt_ctl #(
  parameter int unsigned NUM_BUTTONS = btt_pkg::NUM_BUTTONS_DEF,
  localparam int unsigned IW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,     // frame start word accepted
  input  logic          finish_i,    // finish word accepted
  input  logic          out_free_i,  // output register can take a word
  output btt_pkg::seq_t ctl_o,
  output logic [IW-1:0] addr_o,
  output logic [IW-1:0] s1_idx_o
);

  localparam logic [IW:0] CNT_LAST = (IW+1)'(NUM_BUTTONS - 1);
  localparam logic [IW:0] CNT_END  = (IW+1)'(NUM_BUTTONS);
  localparam logic [IW-1:0] IDX_LAST = IW'(NUM_BUTTONS - 1);

  btt_pkg::state_e state_q, state_d;
  logic [IW:0]     cnt_q, cnt_d;
  logic            s1_valid_q, s1_valid_d;
  logic [IW-1:0]   s1_idx_q, s1_idx_d;
  logic            cnt_last;
  logic            issue;
  logic            load;
  logic            s1_last;

  assign cnt_last = (cnt_q == CNT_LAST);
  assign s1_last  = (s1_idx_q == IDX_LAST);
  assign load     = s1_valid_q && out_free_i;
  assign issue    = (state_q == btt_pkg::ST_EMIT) && (cnt_q != CNT_END) &&
                    (!s1_valid_q || out_free_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      btt_pkg::ST_CLEAR: begin
        if (cnt_last) state_d = btt_pkg::ST_IDLE;
      end
      btt_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = btt_pkg::ST_SWEEP;
        end else if (finish_i) begin
          state_d = btt_pkg::ST_EMIT;
        end
      end
      btt_pkg::ST_SWEEP: begin
        if (cnt_last) state_d = btt_pkg::ST_IDLE;
      end
      btt_pkg::ST_EMIT: begin
        if (load && s1_last) state_d = btt_pkg::ST_IDLE;
      end
      default: state_d = btt_pkg::ST_IDLE;
    endcase
  end

  // outputs, counter and read stage tracking
  always_comb begin
    ctl_o.busy    = (state_q != btt_pkg::ST_IDLE);
    ctl_o.clr     = (state_q == btt_pkg::ST_CLEAR);
    ctl_o.sweep   = (state_q == btt_pkg::ST_SWEEP);
    ctl_o.emit_rd = issue;
    ctl_o.s1_load = load;
    ctl_o.s1_last = s1_last;

    cnt_d = cnt_q;
    case (state_q)
      btt_pkg::ST_CLEAR,
      btt_pkg::ST_SWEEP: cnt_d = cnt_last ? '0 : cnt_q + 1'b1;
      btt_pkg::ST_EMIT: begin
        if (load && s1_last) begin
          cnt_d = '0;
        end else if (issue) begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: cnt_d = '0;
    endcase

    s1_valid_d = s1_valid_q;
    s1_idx_d   = s1_idx_q;
    if (issue) begin
      s1_valid_d = 1'b1;
      s1_idx_d   = cnt_q[IW-1:0];
    end else if (load) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= btt_pkg::ST_CLEAR;
      cnt_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_idx_q   <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      s1_valid_q <= s1_valid_d;
      s1_idx_q   <= s1_idx_d;
    end
  end

  assign addr_o   = cnt_q[IW-1:0];
  assign s1_idx_o = s1_idx_q;

endmodule : btt_ctl

FILE: rtl/btt_rec.sv
// ----------------------------------------------------------------------------
// btt_rec
// Builds one per-button record from RAM read data and frame state, and holds
// it in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btt_rec #(
  parameter int unsigned NUM_BUTTONS = btt_pkg::NUM_BUTTONS_DEF,
  parameter int unsigned TIME_BITS   = btt_pkg::TIME_BITS_DEF,
  localparam int unsigned IW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  logic                        last_i,
  input  logic [IW-1:0]               idx_i,
  input  logic [2*TIME_BITS-1:0]      edge_data_i,  // {release, press}
  input  logic [2*TIME_BITS-1:0]      evt_data_i,   // {last release, first press}
  input  logic [NUM_BUTTONS-1:0]      frame_mask_i,
  input  logic [NUM_BUTTONS-1:0]      prev_mask_i,
  input  logic [btt_pkg::NUM_FLAG_MASKS-1:0][NUM_BUTTONS-1:0] flag_masks_i,
  input  logic [btt_pkg::NUM_COUNTERS-1:0][btt_pkg::CNT_W-1:0] counts_i,
  input  logic [TIME_BITS-1:0]        frame_time_i,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic                        out_free_o,
  output logic [btt_pkg::IDX_W-1:0]   button_index_o,
  output logic [btt_pkg::FLAG_W-1:0]  flags_o,
  output logic [btt_pkg::TIME_W-1:0]  pressed_at_us_o,
  output logic [btt_pkg::TIME_W-1:0]  released_at_us_o,
  output logic [btt_pkg::TIME_W-1:0]  held_us_o,
  output logic [btt_pkg::TIME_W-1:0]  first_press_us_o,
  output logic [btt_pkg::TIME_W-1:0]  last_release_us_o,
  output logic [btt_pkg::CNT_W-1:0]   gesture_count_o,
  output logic [btt_pkg::CNT_W-1:0]   touch_press_count_o,
  output logic [btt_pkg::CNT_W-1:0]   touch_release_count_o,
  output logic [btt_pkg::CNT_W-1:0]   touch_slide_count_o,
  output logic                        last_record_o
);

  logic                        valid_q, valid_d;
  logic [btt_pkg::FLAG_W-1:0]  flags_d, flags_q;
  logic [TIME_BITS-1:0]        press_t, rel_t, held_d;
  logic                        down, prev;
  logic [btt_pkg::IDX_W-1:0]   idx_q;
  logic [btt_pkg::TIME_W-1:0]  press_q, rel_q, held_q, first_q, lastrel_q;
  logic [btt_pkg::NUM_COUNTERS-1:0][btt_pkg::CNT_W-1:0] counts_q;
  logic                        last_q;

  assign press_t = edge_data_i[TIME_BITS-1:0];
  assign rel_t   = edge_data_i[2*TIME_BITS-1:TIME_BITS];
  assign down    = frame_mask_i[idx_i];
  assign prev    = prev_mask_i[idx_i];

  always_comb begin
    flags_d = '0;
    flags_d[btt_pkg::FLG_DOWN]     = down;
    flags_d[btt_pkg::FLG_PRESSED]  = down && !prev;
    flags_d[btt_pkg::FLG_RELEASED] = !down && prev;
    flags_d[btt_pkg::FLG_HELD]     = down && prev;
    flags_d[btt_pkg::FLG_SAWPRESS] = flag_masks_i[btt_pkg::EV_PRESS][idx_i];
    flags_d[btt_pkg::FLG_SAWREL]   = flag_masks_i[btt_pkg::EV_RELEASE][idx_i];
    flags_d[btt_pkg::FLG_TAP]      = flag_masks_i[btt_pkg::EV_TAP][idx_i];
    flags_d[btt_pkg::FLG_HOLD]     = flag_masks_i[btt_pkg::EV_HOLD][idx_i];
    flags_d[btt_pkg::FLG_COMBO]    = flag_masks_i[btt_pkg::EV_COMBO][idx_i];
    // pulse: pressed and released by events while up at frame start
    flags_d[btt_pkg::FLG_PULSE]    = flag_masks_i[btt_pkg::EV_PRESS][idx_i] &&
                                     flag_masks_i[btt_pkg::EV_RELEASE][idx_i] && !down;
  end

  assign held_d = (down && (press_t != '0) && (frame_time_i >= press_t)) ?
                  (frame_time_i - press_t) : '0;

  assign out_free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      idx_q     <= btt_pkg::IDX_W'(idx_i);
      flags_q   <= flags_d;
      press_q   <= btt_pkg::TIME_W'(press_t);
      rel_q     <= btt_pkg::TIME_W'(rel_t);
      held_q    <= btt_pkg::TIME_W'(held_d);
      first_q   <= btt_pkg::TIME_W'(evt_data_i[TIME_BITS-1:0]);
      lastrel_q <= btt_pkg::TIME_W'(evt_data_i[2*TIME_BITS-1:TIME_BITS]);
      counts_q  <= counts_i;
      last_q    <= last_i;
    end
  end

  assign out_valid_o           = valid_q;
  assign button_index_o        = idx_q;
  assign flags_o               = flags_q;
  assign pressed_at_us_o       = press_q;
  assign released_at_us_o      = rel_q;
  assign held_us_o             = held_q;
  assign first_press_us_o      = first_q;
  assign last_release_us_o     = lastrel_q;
  assign gesture_count_o       = counts_q[0];
  assign touch_press_count_o   = counts_q[1];
  assign touch_release_count_o = counts_q[2];
  assign touch_slide_count_o   = counts_q[3];
  assign last_record_o         = last_q;

endmodule : btt_rec

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the button edge timestamp tracker. A queue of input
// words (frame start, events, finish) feeds a bursty driver. Every accepted
// word updates a cycle-free tracker model, and each finish queues the 32
// records that the block must return. A monitor compares the records field
// by field while the receive side stalls on its own pattern.
// ----------------------------------------------------------------------------

module testbench;

  localparam int NBTN           = btt_pkg::NUM_BUTTONS_DEF;
  localparam int MASK_W         = btt_pkg::MASK_W;
  localparam int TIME_W         = btt_pkg::TIME_W;
  localparam int KIND_W         = btt_pkg::KIND_W;
  localparam int IDX_W          = btt_pkg::IDX_W;
  localparam int FLAG_W         = btt_pkg::FLAG_W;
  localparam int CNT_W          = btt_pkg::CNT_W;
  localparam int NUM_FLAG_MASKS = btt_pkg::NUM_FLAG_MASKS;
  localparam int NUM_COUNTERS   = btt_pkg::NUM_COUNTERS;
  localparam int RANDOM_WORDS   = 256;   // words in the random part
  localparam int QUIET_LIMIT    = 3000;  // cycles with no handshake on either side
  localparam int SETTLE_CYCLES  = 40;    // frame start sweep plus record latency
  localparam int LONG_HOLD      = 240;   // one long receive hold-off
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // One input word; wait_drained makes the driver hold it back until every
  // queued record has come out.
  typedef struct packed {
    btt_pkg::cmd_e     cmd;
    logic [MASK_W-1:0] mask;
    logic [TIME_W-1:0] t;
    logic [KIND_W-1:0] kind;
    logic [MASK_W-1:0] code;
    bit                wait_drained;
  } word_t;

  // One per-button record as it leaves the block
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [FLAG_W-1:0] flags;
    logic [TIME_W-1:0] pressed_at;
    logic [TIME_W-1:0] released_at;
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] first_press;
    logic [TIME_W-1:0] last_release;
    logic [CNT_W-1:0]  gestures;
    logic [CNT_W-1:0]  tpresses;
    logic [CNT_W-1:0]  treleases;
    logic [CNT_W-1:0]  tslides;
    logic              last;
  } record_t;

  // Receive side stall patterns
  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_BEAT} rx_mode_e;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  btt_pkg::cmd_e     command   = btt_pkg::CMD_START;
  logic [MASK_W-1:0] down_mask = '0;
  logic [TIME_W-1:0] time_us   = '0;
  logic [KIND_W-1:0] ev_kind   = '0;
  logic [MASK_W-1:0] ev_code   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [IDX_W-1:0]  button_index;
  logic [FLAG_W-1:0] flags;
  logic [TIME_W-1:0] pressed_at_us;
  logic [TIME_W-1:0] released_at_us;
  logic [TIME_W-1:0] held_us;
  logic [TIME_W-1:0] first_press_us;
  logic [TIME_W-1:0] last_release_us;
  logic [CNT_W-1:0]  gesture_count;
  logic [CNT_W-1:0]  touch_press_count;
  logic [CNT_W-1:0]  touch_release_count;
  logic [CNT_W-1:0]  touch_slide_count;
  logic              last_record;

  word_t   pending[$];      // words still to be offered
  record_t records_due[$];  // records owed by the block, oldest first
  int      mismatches      = 0;
  int      records_checked = 0;
  int      quiet_cycles    = 0;
  bit      wind_down       = 1'b0;

  // Tracker model state
  logic [MASK_W-1:0] mask_before;
  logic [MASK_W-1:0] mask_now;
  logic [TIME_W-1:0] frame_stamp;
  logic [TIME_W-1:0] press_edge_at   [NBTN];
  logic [TIME_W-1:0] release_edge_at [NBTN];
  logic [TIME_W-1:0] earliest_press  [NBTN];
  logic [TIME_W-1:0] latest_release  [NBTN];
  logic [MASK_W-1:0] seen_mask       [NUM_FLAG_MASKS];
  logic [CNT_W-1:0]  event_tally     [NUM_COUNTERS];

  always #5 clk_i = ~clk_i;

  button_edge_timestamp_tracker dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid),
    .in_stall_o            (in_stall),
    .command_i             (command),
    .down_mask_i           (down_mask),
    .time_us_i             (time_us),
    .event_kind_i          (ev_kind),
    .event_code_i          (ev_code),
    .out_valid_o           (out_valid),
    .out_stall_i           (out_stall),
    .button_index_o        (button_index),
    .flags_o               (flags),
    .pressed_at_us_o       (pressed_at_us),
    .released_at_us_o      (released_at_us),
    .held_us_o             (held_us),
    .first_press_us_o      (first_press_us),
    .last_release_us_o     (last_release_us),
    .gesture_count_o       (gesture_count),
    .touch_press_count_o   (touch_press_count),
    .touch_release_count_o (touch_release_count),
    .touch_slide_count_o   (touch_slide_count),
    .last_record_o         (last_record)
  );

  // --------------------------------------------------------------------------
  // Tracker model: apply one accepted word, queue the records a finish owes.
  // --------------------------------------------------------------------------
  task automatic track_word(input word_t w);
    logic [MASK_W-1:0] rose;
    logic [MASK_W-1:0] fell;
    logic [MASK_W-1:0] steady;
    logic [MASK_W-1:0] pulse;
    logic [TIME_W-1:0] t;
    record_t           r;
    int                b;
    case (w.cmd)
      btt_pkg::CMD_START: begin
        // Edges are this frame's mask against the one before it
        mask_before = mask_now;
        mask_now    = w.mask;
        frame_stamp = w.t;
        rose = mask_now & ~mask_before;
        fell = mask_before & ~mask_now;
        for (int i = 0; i < NBTN; i++) begin
          if (rose[i]) press_edge_at[i] = w.t;
          if (fell[i]) release_edge_at[i] = w.t;
          earliest_press[i] = '0;
          latest_release[i] = '0;
        end
        for (int k = 0; k < NUM_FLAG_MASKS; k++) seen_mask[k] = '0;
        for (int k = 0; k < NUM_COUNTERS; k++) event_tally[k] = '0;
      end
      btt_pkg::CMD_EVENT: begin
        // A zero event time stands for the frame time
        t = (w.t == '0) ? frame_stamp : w.t;
        if (w.kind >= btt_pkg::EV_GESTURE && w.kind <= btt_pkg::EV_TSLIDE) begin
          // Counters saturate and ignore the code
          b = w.kind - btt_pkg::EV_GESTURE;
          if (event_tally[b] != '1) event_tally[b] = event_tally[b] + 1'b1;
        end else if (w.kind <= btt_pkg::EV_COMBO && w.code != '0 &&
                     (w.code & (w.code - 1'b1)) == '0) begin
          // Button events act only on a code with a single bit set
          b = 0;
          while (!w.code[b]) b++;
          seen_mask[w.kind] |= w.code;
          if (w.kind == btt_pkg::EV_PRESS &&
              (earliest_press[b] == '0 || t < earliest_press[b]))
            earliest_press[b] = t;
          if (w.kind == btt_pkg::EV_RELEASE && t > latest_release[b])
            latest_release[b] = t;
        end
      end
      btt_pkg::CMD_FINISH: begin
        rose   = mask_now & ~mask_before;
        fell   = mask_before & ~mask_now;
        steady = mask_now & mask_before;
        // Pulse: pressed and released by events while not down at frame start
        pulse  = seen_mask[btt_pkg::EV_PRESS] & seen_mask[btt_pkg::EV_RELEASE] &
                 ~mask_now;
        for (int i = 0; i < NBTN; i++) begin
          r.idx                          = IDX_W'(i);
          r.flags                        = '0;
          r.flags[btt_pkg::FLG_DOWN]     = mask_now[i];
          r.flags[btt_pkg::FLG_PRESSED]  = rose[i];
          r.flags[btt_pkg::FLG_RELEASED] = fell[i];
          r.flags[btt_pkg::FLG_HELD]     = steady[i];
          r.flags[btt_pkg::FLG_SAWPRESS] = seen_mask[btt_pkg::EV_PRESS][i];
          r.flags[btt_pkg::FLG_SAWREL]   = seen_mask[btt_pkg::EV_RELEASE][i];
          r.flags[btt_pkg::FLG_TAP]      = seen_mask[btt_pkg::EV_TAP][i];
          r.flags[btt_pkg::FLG_HOLD]     = seen_mask[btt_pkg::EV_HOLD][i];
          r.flags[btt_pkg::FLG_COMBO]    = seen_mask[btt_pkg::EV_COMBO][i];
          r.flags[btt_pkg::FLG_PULSE]    = pulse[i];
          r.pressed_at                   = press_edge_at[i];
          r.released_at                  = release_edge_at[i];
          // Held time is zero when up, never stamped, or stamped in the future
          r.held = (mask_now[i] && press_edge_at[i] != '0 &&
                    frame_stamp >= press_edge_at[i]) ?
                   frame_stamp - press_edge_at[i] : '0;
          r.first_press                  = earliest_press[i];
          r.last_release                 = latest_release[i];
          r.gestures                     = event_tally[0];
          r.tpresses                     = event_tally[1];
          r.treleases                    = event_tally[2];
          r.tslides                      = event_tally[3];
          r.last                         = (i == NBTN - 1);
          records_due.push_back(r);
        end
      end
      default: ;  // unused command leaves everything alone
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Word builders
  // --------------------------------------------------------------------------
  function automatic logic [TIME_W-1:0] any_time();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[TIME_W-1:0];
  endfunction

  // Unused fields carry noise so that every bit toggles
  function automatic word_t blank_word(input btt_pkg::cmd_e c);
    word_t w;
    w.cmd          = c;
    w.mask         = $urandom;
    w.t            = any_time();
    w.kind         = KIND_W'($urandom_range(0, 15));
    w.code         = $urandom;
    w.wait_drained = 1'b0;
    return w;
  endfunction

  function automatic word_t start_word(input logic [MASK_W-1:0] mask,
                                       input logic [TIME_W-1:0] t);
    word_t w;
    w      = blank_word(btt_pkg::CMD_START);
    w.mask = mask;
    w.t    = t;
    return w;
  endfunction

  function automatic word_t event_word(input logic [KIND_W-1:0] kind,
                                       input logic [MASK_W-1:0] code,
                                       input logic [TIME_W-1:0] t);
    word_t w;
    w      = blank_word(btt_pkg::CMD_EVENT);
    w.kind = kind;
    w.code = code;
    w.t    = t;
    return w;
  endfunction

  // Mostly near the base, sometimes zero, random or close to the top
  function automatic logic [TIME_W-1:0] pick_time(input logic [TIME_W-1:0] base);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return any_time();
      2:       return TIME_MAX - TIME_W'($urandom_range(0, 1000));
      default: return base + TIME_W'($urandom_range(0, 3000));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers pending words in bursts; a stalled word is held unchanged.
  // --------------------------------------------------------------------------
  word_t offered;
  int    burst_left = 0;
  int    gap_left   = 0;

  always @(posedge clk_i) begin
    word_t w;
    if (rst_ni) begin
      if (in_valid && !in_stall) track_word(offered);
      if (in_valid && in_stall) begin
        // keep offering the same word
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending.size() == 0 ||
                   (pending[0].wait_drained && records_due.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        w         = pending.pop_front();
        offered   = w;
        command   <= w.cmd;
        down_mask <= w.mask;
        time_us   <= w.t;
        ev_kind   <= w.kind;
        ev_code   <= w.code;
        in_valid  <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receive side: stall pattern is redrawn after a random run; once, after a
  // couple of frames, it holds off long enough for the block to back up.
  // --------------------------------------------------------------------------
  rx_mode_e rx_mode        = RX_FREE;
  int       rx_mode_left   = 0;
  int       rx_tick        = 0;
  int       long_hold_left = 0;
  bit       long_hold_done = 1'b0;

  always @(posedge clk_i) begin
    logic hold;
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(16, 96);
    end
    rx_mode_left--;
    rx_tick++;
    case (rx_mode)
      RX_FREE:  hold = 1'b0;
      RX_LIGHT: hold = ($urandom_range(0, 3) == 0);
      RX_HEAVY: hold = ($urandom_range(0, 3) != 0);
      default:  hold = (rx_tick % 3 != 0);
    endcase
    if (long_hold_left != 0) begin
      long_hold_left--;
      hold = 1'b1;
    end else if (!long_hold_done && records_checked >= 64) begin
      long_hold_left = LONG_HOLD;
      long_hold_done = 1'b1;
      hold = 1'b1;
    end
    if (wind_down) hold = 1'b0;
    out_stall <= hold;
  end

  // --------------------------------------------------------------------------
  // Monitor: every accepted record against the oldest one owed
  // --------------------------------------------------------------------------
  task automatic check_field(input int btn, input string name,
                             input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: button %0d %s expected %0h, got %0h",
               $time, btn, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    record_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (records_due.size() == 0) begin
        mismatches++;
        $display("%0t: record for button %0d with none expected, got index %0d",
                 $time, button_index, button_index);
      end else begin
        want = records_due.pop_front();
        check_field(want.idx, "button_index", want.idx, button_index);
        check_field(want.idx, "flags", want.flags, flags);
        check_field(want.idx, "pressed_at_us", want.pressed_at, pressed_at_us);
        check_field(want.idx, "released_at_us", want.released_at, released_at_us);
        check_field(want.idx, "held_us", want.held, held_us);
        check_field(want.idx, "first_press_us", want.first_press, first_press_us);
        check_field(want.idx, "last_release_us", want.last_release, last_release_us);
        check_field(want.idx, "gesture_count", want.gestures, gesture_count);
        check_field(want.idx, "touch_press_count", want.tpresses, touch_press_count);
        check_field(want.idx, "touch_release_count", want.treleases,
                    touch_release_count);
        check_field(want.idx, "touch_slide_count", want.tslides, touch_slide_count);
        check_field(want.idx, "last_record", want.last, last_record);
        records_checked <= records_checked + 1;
      end
    end
  end

  // Watchdog: too long with no word moving on either side
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d records owed",
               $time, QUIET_LIMIT, records_due.size());
      $display("testbench: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    word_t             w;
    logic [MASK_W-1:0] gen_mask;
    logic [TIME_W-1:0] gen_stamp;
    logic [TIME_W-1:0] gen_frame_t;
    logic [KIND_W-1:0] kind;
    logic [MASK_W-1:0] code;
    int                frame_words;
    int                n_events;
    int                hot;

    // Model state after reset
    mask_before = '0;
    mask_now    = '0;
    frame_stamp = '0;
    for (int i = 0; i < NBTN; i++) begin
      press_edge_at[i]   = '0;
      release_edge_at[i] = '0;
      earliest_press[i]  = '0;
      latest_release[i]  = '0;
    end
    for (int k = 0; k < NUM_FLAG_MASKS; k++) seen_mask[k] = '0;
    for (int k = 0; k < NUM_COUNTERS; k++) event_tally[k] = '0;

    // Directed: finish straight after reset, unused command, all buttons down
    // at the top time, every event kind, bad codes, ignored kinds.
    pending.push_back(blank_word(btt_pkg::CMD_FINISH));
    pending.push_back(blank_word(btt_pkg::CMD_NONE));
    pending.push_back(start_word('1, TIME_MAX));
    pending.push_back(event_word(btt_pkg::EV_PRESS, 32'h8000_0000, '0));
    pending.push_back(event_word(btt_pkg::EV_RELEASE, 32'h0000_0001, 48'd1));
    pending.push_back(event_word(btt_pkg::EV_TAP, '0, any_time()));
    pending.push_back(event_word(btt_pkg::EV_HOLD, 32'h0000_0003, any_time()));
    pending.push_back(event_word(btt_pkg::EV_COMBO, 32'h0000_0020, TIME_MAX));
    pending.push_back(event_word(btt_pkg::EV_GESTURE, $urandom, any_time()));
    pending.push_back(event_word(btt_pkg::EV_TPRESS, $urandom, any_time()));
    pending.push_back(event_word(btt_pkg::EV_TRELEASE, $urandom, any_time()));
    pending.push_back(event_word(btt_pkg::EV_TSLIDE, $urandom, any_time()));
    pending.push_back(event_word(btt_pkg::EV_IGNORE, 32'h0000_0004, any_time()));
    pending.push_back(event_word(4'hF, 32'h0000_0004, any_time()));
    pending.push_back(blank_word(btt_pkg::CMD_FINISH));
    pending.push_back(blank_word(btt_pkg::CMD_FINISH));  // same records again
    // Everything released at time zero, then a pulse on button 7 with an
    // earlier second press
    pending.push_back(start_word('0, '0));
    pending.push_back(event_word(btt_pkg::EV_PRESS, 32'h0000_0080, 48'd100));
    pending.push_back(event_word(btt_pkg::EV_RELEASE, 32'h0000_0080, 48'd50));
    pending.push_back(event_word(btt_pkg::EV_PRESS, 32'h0000_0080, 48'd20));
    pending.push_back(blank_word(btt_pkg::CMD_FINISH));
    // Sender waits for the records; then a press stamped after the frame time
    w = start_word(32'h0000_0080, 48'd10);
    w.wait_drained = 1'b1;
    pending.push_back(w);
    pending.push_back(start_word(32'h0000_0080, 48'd5));
    pending.push_back(blank_word(btt_pkg::CMD_FINISH));

    // Random: mostly whole frames, some stray words.
    gen_mask    = 32'h0000_0080;
    gen_stamp   = 48'd1000;
    frame_words = 0;
    while (frame_words < RANDOM_WORDS) begin
      gen_stamp = gen_stamp + TIME_W'($urandom_range(1, 5000));
      case ($urandom_range(0, 9))
        0:       gen_mask = '0;
        1:       gen_mask = '1;
        2:       gen_mask = $urandom;
        default: gen_mask = gen_mask ^ (32'h1 << $urandom_range(0, 31))
                                     ^ (($urandom_range(0, 1) == 0) ? '0 :
                                        (32'h1 << $urandom_range(0, 31)));
      endcase
      gen_frame_t = pick_time(gen_stamp);
      hot = $urandom_range(0, 31);
      if ($urandom_range(0, 6) == 0) begin
        pending.push_back(blank_word(btt_pkg::cmd_e'($urandom_range(0, 3))));
        frame_words++;
      end else begin
        w = start_word(gen_mask, gen_frame_t);
        w.wait_drained = ($urandom_range(0, 11) == 0);
        pending.push_back(w);
        n_events = $urandom_range(0, 12);
        for (int j = 0; j < n_events; j++) begin
          case ($urandom_range(0, 19)) inside
            [0:11]:  kind = KIND_W'($urandom_range(btt_pkg::EV_PRESS,
                                                   btt_pkg::EV_COMBO));
            [12:16]: kind = KIND_W'($urandom_range(btt_pkg::EV_GESTURE,
                                                   btt_pkg::EV_TSLIDE));
            default: kind = KIND_W'($urandom_range(btt_pkg::EV_IGNORE, 15));
          endcase
          case ($urandom_range(0, 9))
            0:       code = '0;
            1:       code = $urandom;
            2, 3, 4, 5: code = 32'h1 << hot;
            default: code = 32'h1 << $urandom_range(0, 31);
          endcase
          pending.push_back(event_word(kind, code, pick_time(gen_frame_t)));
        end
        pending.push_back(blank_word(btt_pkg::CMD_FINISH));
        frame_words += n_events + 2;
        if ($urandom_range(0, 7) == 0) begin
          pending.push_back(blank_word(btt_pkg::CMD_FINISH));
          frame_words++;
        end
      end
    end

    // Reset once; the block runs its clearing pass with input stalled
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (pending.size() != 0 || in_valid || records_due.size() != 0);
    wind_down = 1'b1;
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (mismatches == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/btt_pkg.sv
rtl/btt_ram.sv
rtl/btt_ctl.sv
rtl/btt_rec.sv
rtl/button_edge_timestamp_tracker.sv
bench/testbench.sv
